@@ hdl/ghcdc_pkg.sv @@
`timescale 1ns / 1ps
// package for the gear hash content defined chunker
// holds the fixed widths, register codes, shared structs and the gear table rom
// no dependencies
package ghcdc_pkg;

	// fixed field widths
	localparam int CFG_W     = 24;
	localparam int LOG_W     = 5;
	localparam int END_W     = 48;
	localparam int HASH_W    = 64;
	localparam int AVG_W     = 32;
	localparam int IDX_W     = 2;

	// register reset values
	localparam logic [CFG_W-1:0] MIN_CHUNK_RST = 24'd2048;
	localparam logic [LOG_W-1:0] AVG_LOG2_RST  = 5'd13;
	localparam logic [CFG_W-1:0] MAX_CHUNK_RST = 24'd65536;

	// splitmix64 constants
	localparam logic [63:0] GEAR_SEED = 64'h434d504354434443;
	localparam logic [63:0] MIX_INC   = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_MIN_CHUNK = 2'd0,
		CFG_AVG_LOG2  = 2'd1,
		CFG_MAX_CHUNK = 2'd2
	} cfg_reg_t;

	// decoded configuration seen by the hash core
	typedef struct packed {
		logic              valid;
		logic [CFG_W-1:0]  min_chunk;
		logic [CFG_W-1:0]  max_chunk;
		logic [AVG_W-1:0]  avg;
		logic [HASH_W-1:0] early_mask;
		logic [HASH_W-1:0] late_mask;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic             valid;
		logic [END_W-1:0] end_offset;
		logic             final_chunk;
		logic             config_error;
	} res_t;

	typedef logic [HASH_W-1:0] gear_rom_t [256];

	// gear table: 256 successive splitmix64 outputs, evaluated at elaboration
	function automatic gear_rom_t gear_build();
		gear_rom_t   rom;
		logic [63:0] st;
		logic [63:0] z;
		st = GEAR_SEED;
		for (int k = 0; k < 256; k++) begin
			st = st + MIX_INC;
			z = st;
			z = (z ^ (z >> 30)) * MIX_MUL1;
			z = (z ^ (z >> 27)) * MIX_MUL2;
			rom[k] = z ^ (z >> 31);
		end
		return rom;
	endfunction

	localparam gear_rom_t GEAR_ROM = gear_build();

endpackage

@@ hdl/ghcdc_cfg.sv @@
`timescale 1ns / 1ps
// configuration registers and their decode into masks and a validity flag
// depends on ghcdc_pkg
module ghcdc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ghcdc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ghcdc_pkg::CFG_W-1:0] cfg_data,
	output ghcdc_pkg::cfg_t            cfg
);
	import ghcdc_pkg::*;

	logic [CFG_W-1:0] min_chunk_q;
	logic [LOG_W-1:0] avg_log2_q;
	logic [CFG_W-1:0] max_chunk_q;
	logic [AVG_W-1:0] avg;
	logic [5:0]       early_bits;
	logic [5:0]       late_bits;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_chunk_q <= MIN_CHUNK_RST;
			avg_log2_q  <= AVG_LOG2_RST;
			max_chunk_q <= MAX_CHUNK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MIN_CHUNK: min_chunk_q <= cfg_data;
				CFG_AVG_LOG2:  avg_log2_q  <= cfg_data[LOG_W-1:0];
				CFG_MAX_CHUNK: max_chunk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// average size and mask decode
	always_comb begin
		avg        = AVG_W'(1) << avg_log2_q;
		early_bits = 6'(avg_log2_q) + 6'd1;
		late_bits  = 6'(avg_log2_q) - 6'd1;
		cfg.min_chunk  = min_chunk_q;
		cfg.max_chunk  = max_chunk_q;
		cfg.avg        = avg;
		cfg.valid      = (min_chunk_q != '0) && (avg >= AVG_W'(min_chunk_q))
			&& (AVG_W'(max_chunk_q) >= avg);
		cfg.early_mask = ~({HASH_W{1'b1}} << early_bits);
		// all ones when the average is one byte
		cfg.late_mask  = (avg_log2_q == '0) ? {HASH_W{1'b1}}
			: ~({HASH_W{1'b1}} << late_bits);
	end

endmodule

@@ hdl/ghcdc_core.sv @@
`timescale 1ns / 1ps
// rolling gear hash, chunk position and stream offset with the cut decision
// depends on ghcdc_pkg
module ghcdc_core #(
	parameter int OFFSET_BITS = 48,
	parameter int SIZE_BITS   = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  ghcdc_pkg::cfg_t cfg,
	output ghcdc_pkg::res_t res
);
	import ghcdc_pkg::*;

	localparam int CMP_W = (SIZE_BITS + 1 > AVG_W) ? SIZE_BITS + 1 : AVG_W;

	logic [HASH_W-1:0]      hash_q;
	logic [SIZE_BITS-1:0]   pos_q;
	logic [OFFSET_BITS-1:0] off_q;

	logic [CMP_W-1:0]       r_ext;
	logic [CMP_W-1:0]       r_next;
	logic                   hashing;
	logic [HASH_W-1:0]      mask;
	logic [HASH_W-1:0]      hash_new;
	logic                   cut;
	logic [OFFSET_BITS-1:0] next_off;
	logic [63:0]            off_ext;

	// hash step and cut test
	always_comb begin
		r_ext    = CMP_W'(pos_q);
		r_next   = r_ext + CMP_W'(1);
		hashing  = r_ext >= CMP_W'(cfg.min_chunk);
		mask     = (r_ext < CMP_W'(cfg.avg)) ? cfg.early_mask : cfg.late_mask;
		hash_new = (hash_q << 1) + GEAR_ROM[data_byte];
		cut      = (hashing && ((hash_new & mask) == '0))
			|| (r_next >= CMP_W'(cfg.max_chunk)) || last_byte;
		next_off = off_q + OFFSET_BITS'(1);
		off_ext  = 64'(next_off);
	end

	// result for the item now in the input register
	always_comb begin
		if (!cfg.valid) begin
			res.valid        = last_byte;
			res.end_offset   = '0;
			res.final_chunk  = 1'b0;
			res.config_error = 1'b1;
		end else begin
			res.valid        = cut;
			res.end_offset   = off_ext[END_W-1:0];
			res.final_chunk  = last_byte;
			res.config_error = 1'b0;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pos_q  <= '0;
			off_q  <= '0;
		end else if (take) begin
			if (!cfg.valid) begin
				if (last_byte) begin
					hash_q <= '0;
					pos_q  <= '0;
					off_q  <= '0;
				end else begin
					pos_q <= pos_q + SIZE_BITS'(1);
					off_q <= next_off;
				end
			end else if (cut) begin
				hash_q <= '0;
				pos_q  <= '0;
				off_q  <= last_byte ? '0 : next_off;
			end else begin
				if (hashing)
					hash_q <= hash_new;
				pos_q <= pos_q + SIZE_BITS'(1);
				off_q <= next_off;
			end
		end
	end

endmodule

@@ hdl/gear_hash_content_defined_chunker.sv @@
`timescale 1ns / 1ps
// top level of the gear hash content defined chunker: input register, hash core, result register
// depends on ghcdc_pkg, ghcdc_cfg and ghcdc_core
//
// One byte item is taken per clock cycle, back to back, while in_stall is low. A byte sits
// in the input register until the core takes it; its result item is loaded into the result
// register as the core takes the byte and shows on the output from there. The rate is
// set by that one pass: gear table lookup, 64-bit shift-add and mask test. A held result
// stalls the byte stream only when a new result needs the output register. Bytes up to
// the minimum size are not hashed; a cut is made on a mask hit, at the maximum size or on
// the last byte. Write configuration only while no byte is in flight; an invalid setting
// gives a single error result on the last byte of the stream. No clearing pass is needed
// after reset.
module gear_hash_content_defined_chunker #(
	parameter int OFFSET_BITS = 48,
	parameter int SIZE_BITS   = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ghcdc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ghcdc_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ghcdc_pkg::END_W-1:0] end_offset,
	output logic                        final_chunk,
	output logic                        config_error
);
	import ghcdc_pkg::*;

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_free;
	logic       take;
	logic       accept;
	logic       out_valid_q;
	logic [END_W-1:0] end_offset_q;
	logic       final_chunk_q;
	logic       config_error_q;

	ghcdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ghcdc_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.SIZE_BITS   (SIZE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// handshake: the registered item moves on unless its result finds the output full
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		take     = valid_s1 && (!res.valid || out_free);
		in_stall = valid_s1 && !take;
		accept   = in_valid && !in_stall;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			end_offset_q   <= res.end_offset;
			final_chunk_q  <= res.final_chunk;
			config_error_q <= res.config_error;
		end
	end

	assign out_valid    = out_valid_q;
	assign end_offset   = end_offset_q;
	assign final_chunk  = final_chunk_q;
	assign config_error = config_error_q;

endmodule

@@ hdl/ghcdc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the gear hash content defined chunker, bound to the top level
// depends on gear_hash_content_defined_chunker
module ghcdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] end_offset,
	input logic        final_chunk,
	input logic        config_error
);

	// an empty output register never holds back the byte stream
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output register empty");

	// error results carry no offset and no final flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> (end_offset == '0) && !final_chunk)
		else $error("error result with payload");

	// a held result stays unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(end_offset)
			&& $stable(final_chunk) && $stable(config_error))
		else $error("stalled result changed");

	// a stalled byte only waits while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled without a pending result");

endmodule

bind gear_hash_content_defined_chunker ghcdc_checker u_ghcdc_checker (.*);

@@ dv/tb_gear_hash_content_defined_chunker.sv @@
`timescale 1ns / 1ps
// self-checking testbench for gear_hash_content_defined_chunker: a clocked driver and monitor,
// a chunk boundary predictor with its own gear table, and phases of directed and random streams
// depends on ghcdc_pkg and the chunker rtl
module tb_gear_hash_content_defined_chunker;
	import ghcdc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int SETTLE       = 6;
	localparam int RAND_ITEMS   = 1600;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_PRINTED  = 30;

	// index beyond the register list, writes to it are dropped
	localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [END_W-1:0] end_offset;
		logic             final_chunk;
		logic             config_error;
	} chunk_end_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0] cfg_data     = '0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic [7:0]       data_byte    = '0;
	logic             last_byte    = 1'b0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic [END_W-1:0] end_offset;
	logic             final_chunk;
	logic             config_error;

	// stimulus and expectation stores
	byte_item_t byte_q[$];
	chunk_end_t chunk_q[$];
	int         bytes_pending = 0;
	int         error_count   = 0;
	int         cycle_count   = 0;
	int         in_idle_pct   = 32;
	int         out_idle_pct  = 32;

	// predictor state and its copy of the registers
	logic [63:0]      gear_tab [256];
	logic [63:0]      gear_hash;
	logic [23:0]      chunk_pos;
	logic [END_W-1:0] stream_off;
	logic [CFG_W-1:0] cur_min;
	logic [LOG_W-1:0] cur_avg_log2;
	logic [CFG_W-1:0] cur_max;

	gear_hash_content_defined_chunker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.end_offset   (end_offset),
		.final_chunk  (final_chunk),
		.config_error (config_error)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// k-th splitmix64 output straight from the seed
	function automatic logic [63:0] gear_entry(input int unsigned k);
		logic [63:0] z;
		z = GEAR_SEED + MIX_INC * {32'd0, k + 32'd1};
		z = (z ^ (z >> 30)) * MIX_MUL1;
		z = (z ^ (z >> 27)) * MIX_MUL2;
		return z ^ (z >> 31);
	endfunction

	// advance the chunker state by one byte, returns 1 when a chunk boundary or an error item comes out
	function automatic bit chunk_step(input logic [7:0] b, input logic last,
			output chunk_end_t res);
		logic [63:0]      avg;
		logic [63:0]      mask;
		logic [24:0]      pos_next;
		logic [END_W-1:0] off_next;
		bit               sizes_ok;
		bit               cut;
		avg      = 64'd1 << cur_avg_log2;
		sizes_ok = (cur_min != '0) && (avg >= {40'd0, cur_min}) && ({40'd0, cur_max} >= avg);
		pos_next = {1'b0, chunk_pos} + 25'd1;
		off_next = stream_off + 1'b1;
		res      = '0;
		cut      = 1'b0;
		// bad sizes: only count, error item on the last byte
		if (!sizes_ok) begin
			if (last) begin
				res.config_error = 1'b1;
				gear_hash  = '0;
				chunk_pos  = '0;
				stream_off = '0;
				return 1'b1;
			end
			chunk_pos  = pos_next[23:0];
			stream_off = off_next;
			return 1'b0;
		end
		// hash past the minimum, wide mask before the average, narrow after it
		if (chunk_pos >= cur_min) begin
			mask      = ({40'd0, chunk_pos} < avg) ? (avg * 2 - 1) : ((avg >> 1) - 1);
			gear_hash = (gear_hash << 1) + gear_tab[b];
			if ((gear_hash & mask) == '0)
				cut = 1'b1;
		end
		if (pos_next >= {1'b0, cur_max} || last)
			cut = 1'b1;
		if (!cut) begin
			chunk_pos  = pos_next[23:0];
			stream_off = off_next;
			return 1'b0;
		end
		res.end_offset  = off_next;
		res.final_chunk = last;
		gear_hash  = '0;
		chunk_pos  = '0;
		stream_off = last ? '0 : off_next;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_chunk(input chunk_end_t got);
		chunk_end_t want;
		if (chunk_q.size() == 0) begin
			report_mismatch($sformatf("item with nothing expected, offset %0d final %0b error %0b",
				got.end_offset, got.final_chunk, got.config_error));
			return;
		end
		want = chunk_q.pop_front();
		if (got.end_offset !== want.end_offset)
			report_mismatch($sformatf("end_offset %0d, expected %0d",
				got.end_offset, want.end_offset));
		if (got.final_chunk !== want.final_chunk)
			report_mismatch($sformatf("final_chunk %0b, expected %0b",
				got.final_chunk, want.final_chunk));
		if (got.config_error !== want.config_error)
			report_mismatch($sformatf("config_error %0b, expected %0b",
				got.config_error, want.config_error));
	endtask

	// register copy follows the write port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_min      <= MIN_CHUNK_RST;
			cur_avg_log2 <= AVG_LOG2_RST;
			cur_max      <= MAX_CHUNK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_CHUNK: cur_min <= cfg_data;
				CFG_AVG_LOG2:  cur_avg_log2 <= cfg_data[LOG_W-1:0];
				CFG_MAX_CHUNK: cur_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// driver: predicts each accepted item, then offers the next one from the queue
	always @(posedge clk or negedge arst_n) begin
		chunk_end_t res;
		byte_item_t nxt;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			data_byte  <= '0;
			last_byte  <= 1'b0;
			gear_hash  = '0;
			chunk_pos  = '0;
			stream_off = '0;
		end else begin
			if (in_valid && !in_stall) begin
				if (chunk_step(data_byte, last_byte, res))
					chunk_q.push_back(res);
				bytes_pending--;
			end
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					nxt = byte_q.pop_front();
					in_valid  <= 1'b1;
					data_byte <= nxt.data;
					last_byte <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks accepted results and stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_chunk({end_offset, final_chunk, config_error});
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		byte_q.push_back('{data: b, last: last});
		bytes_pending++;
	endtask

	task automatic queue_stream(input int len, input bit close);
		for (int i = 0; i < len; i++)
			queue_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
	endtask

	// hold until every byte is taken and every result has come, then let the pipe empty
	task automatic wait_drained();
		do @(posedge clk); while (bytes_pending != 0 || chunk_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] lg,
			input logic [CFG_W-1:0] mx);
		write_reg(CFG_MIN_CHUNK, mn);
		write_reg(CFG_AVG_LOG2, lg);
		write_reg(CFG_MAX_CHUNK, mx);
	endtask

	initial begin
		int          items_sent;
		int          phase;
		int          pick;
		int          budget;
		int          n;
		int          len;
		bit          wide;
		logic [4:0]  lg;
		logic [31:0] avg;
		logic [23:0] mn;
		logic [23:0] mx;

		for (int k = 0; k < 256; k++)
			gear_tab[k] = gear_entry(k);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: nothing cuts before the end of the stream
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h5A, 1'b1);
		wait_drained();

		// dropped write to the spare index, then one-byte chunks
		write_reg(CFG_SPARE, 24'hFFFFFF);
		set_sizes(24'd1, 24'd0, 24'd1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_drained();

		// average of one: late mask is all ones, largest maximum
		write_reg(CFG_MAX_CHUNK, 24'hFFFFFF);
		queue_stream(4, 1'b1);
		wait_drained();

		// zero minimum gives an error item
		write_reg(CFG_MIN_CHUNK, 24'd0);
		queue_stream(3, 1'b1);
		wait_drained();

		// minimum above the average
		set_sizes(24'hFFFFFF, 24'd23, 24'hFFFFFF);
		queue_stream(2, 1'b1);
		wait_drained();

		// maximum below the average
		set_sizes(24'd1, 24'd4, 24'd3);
		queue_stream(2, 1'b1);
		wait_drained();

		// sizes changed in the middle of a stream
		set_sizes(24'd2, 24'd1, 24'd5);
		queue_stream(3, 1'b0);
		wait_drained();
		write_reg(CFG_MAX_CHUNK, 24'd3);
		queue_stream(3, 1'b1);
		wait_drained();

		// random phases, each with fresh sizes
		items_sent = 0;
		phase      = 0;
		while (items_sent < RAND_ITEMS) begin
			wait_drained();
			in_idle_pct  = (phase == 3) ? 0 : 32;
			out_idle_pct = in_idle_pct;
			pick = $urandom_range(0, 99);
			wide = 1'b0;
			if (pick < 75) begin
				lg  = 5'($urandom_range(0, 6));
				avg = 32'd1 << lg;
				mn  = 24'($urandom_range(1, avg));
				mx  = 24'($urandom_range(avg, avg * 4 + 8));
				set_sizes(mn, {19'd0, lg}, mx);
			end else if (pick < 85) begin
				lg  = 5'($urandom_range(7, 12));
				avg = 32'd1 << lg;
				mn  = 24'($urandom_range(1, avg));
				mx  = 24'($urandom_range(avg, avg * 4));
				set_sizes(mn, {19'd0, lg}, mx);
			end else begin
				// anything the fields hold, mostly bad sizes, stray upper bits on the log
				wide = 1'b1;
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_SPARE, 24'($urandom));
				set_sizes(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom),
					24'($urandom_range(0, 24'hFFFFFF)));
			end
			budget = (phase == 3) ? 300 : $urandom_range(40, 160);
			n = 0;
			while (n < budget) begin
				len = wide ? $urandom_range(1, 12) : $urandom_range(1, 64);
				queue_stream(len, $urandom_range(0, 7) != 0);
				n += len;
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
			items_sent += n;
			phase++;
		end

		wait_drained();
		if (chunk_q.size() != 0)
			report_mismatch($sformatf("%0d expected items never came", chunk_q.size()));
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
